FILE: design/rup_pkg.sv
// Shared types, constants and conversion function for the RGB to UYVY packer.
// Used by the front end, the pixel queue and the byte serializer.
package rup_pkg;

   localparam int CFG_W           = 13;
   localparam int DIM_W           = 17;
   localparam int ACC_W           = 27;
   localparam int MAX_LINE_WIDTH_DEF   = 4096;
   localparam int MAX_FRAME_HEIGHT_DEF = 4096;
   localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 13'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

   localparam logic REG_LINE_WIDTH   = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;

   localparam logic signed [ACC_W-1:0] CY_R = 27'sd19595;
   localparam logic signed [ACC_W-1:0] CY_G = 27'sd38470;
   localparam logic signed [ACC_W-1:0] CY_B = 27'sd7471;
   localparam logic signed [ACC_W-1:0] CU_R = -27'sd11076;
   localparam logic signed [ACC_W-1:0] CU_G = -27'sd21692;
   localparam logic signed [ACC_W-1:0] CU_B = 27'sd32768;
   localparam logic signed [ACC_W-1:0] CV_R = 27'sd32768;
   localparam logic signed [ACC_W-1:0] CV_G = -27'sd27460;
   localparam logic signed [ACC_W-1:0] CV_B = -27'sd5374;
   localparam logic signed [ACC_W-1:0] CHROMA_OFS = 27'sd8388608;
   localparam logic signed [ACC_W-1:0] NO_OFS     = 27'sd0;

   typedef struct packed {
      logic [7:0] u;
      logic [7:0] y;
      logic [7:0] v;
      logic       even;
      logic       eof;
   } pix_type;

   function automatic logic [7:0] mix(
      input logic [7:0] r,
      input logic [7:0] g,
      input logic [7:0] b,
      input logic signed [ACC_W-1:0] kr,
      input logic signed [ACC_W-1:0] kg,
      input logic signed [ACC_W-1:0] kb,
      input logic signed [ACC_W-1:0] ofs
   );
      logic signed [ACC_W-1:0] re;
      logic signed [ACC_W-1:0] ge;
      logic signed [ACC_W-1:0] be;
      logic signed [ACC_W-1:0] acc;
      logic [7:0] res;
      re  = $signed({{(ACC_W-8){1'b0}}, r});
      ge  = $signed({{(ACC_W-8){1'b0}}, g});
      be  = $signed({{(ACC_W-8){1'b0}}, b});
      acc = kr * re + kg * ge + kb * be + ofs;
      if (acc[ACC_W-1]) begin
         res = 8'd0;
      end else if (|acc[ACC_W-2:24]) begin
         res = 8'd255;
      end else begin
         res = acc[23:16];
      end
      return res;
   endfunction

endpackage

FILE: design/rup_front.sv
// Front end: config registers, pixel accept, column/row tracking and color conversion.
// Depends on rup_pkg.
module rup_front #(
   parameter int MAX_LINE_WIDTH   = rup_pkg::MAX_LINE_WIDTH_DEF,
   parameter int MAX_FRAME_HEIGHT = rup_pkg::MAX_FRAME_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [rup_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [7:0]                    req_red,
   input  logic [7:0]                    req_green,
   input  logic [7:0]                    req_blue,
   output logic                          q_wr,
   output rup_pkg::pix_type              q_wdata,
   input  logic                          q_full
);
   import rup_pkg::*;

   localparam int COL_W = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
   localparam int ROW_W = (MAX_FRAME_HEIGHT > 1) ? $clog2(MAX_FRAME_HEIGHT) : 1;
   localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_LINE_WIDTH);
   localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAX_FRAME_HEIGHT);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             stage_valid_ff, stage_valid_in;
   logic [7:0]       red_ff, green_ff, blue_ff;
   logic             even_ff, eof_ff;

   logic [DIM_W-1:0] w_clip, w_eff, h_clip, h_eff;
   logic [DIM_W-1:0] col_next, row_next;
   logic             accept, eol, eof;

   always_comb begin
      w_clip = ({{(DIM_W-CFG_W){1'b0}}, width_ff} > MAX_W) ? MAX_W
             : {{(DIM_W-CFG_W){1'b0}}, width_ff};
      w_eff  = {w_clip[DIM_W-1:1], 1'b0};
      if (w_eff < DIM_W'(2)) begin
         w_eff = DIM_W'(2);
      end
      h_clip = ({{(DIM_W-CFG_W){1'b0}}, height_ff} > MAX_H) ? MAX_H
             : {{(DIM_W-CFG_W){1'b0}}, height_ff};
      h_eff  = (h_clip == '0) ? DIM_W'(1) : h_clip;
   end

   assign col_next = DIM_W'(col_ff) + DIM_W'(1);
   assign row_next = DIM_W'(row_ff) + DIM_W'(1);
   assign eol      = col_next >= w_eff;
   assign eof      = eol && (row_next >= h_eff);

   assign req_full       = stage_valid_ff && q_full;
   assign accept         = req_push && !req_full;
   assign q_wr           = stage_valid_ff && !q_full;
   assign stage_valid_in = accept || (stage_valid_ff && q_full);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            REG_LINE_WIDTH:   width_in  = csr_wdata;
            REG_FRAME_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (eol) begin
            col_in = '0;
            row_in = eof ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= LINE_WIDTH_RST;
         height_ff      <= FRAME_HEIGHT_RST;
         col_ff         <= '0;
         row_ff         <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         width_ff       <= width_in;
         height_ff      <= height_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
         even_ff  <= ~col_ff[0];
         eof_ff   <= eof;
      end
   end

   always_comb begin
      q_wdata.u    = mix(red_ff, green_ff, blue_ff, CU_R, CU_G, CU_B, CHROMA_OFS);
      q_wdata.y    = mix(red_ff, green_ff, blue_ff, CY_R, CY_G, CY_B, NO_OFS);
      q_wdata.v    = mix(red_ff, green_ff, blue_ff, CV_R, CV_G, CV_B, CHROMA_OFS);
      q_wdata.even = even_ff;
      q_wdata.eof  = eof_ff;
   end

endmodule

FILE: design/rup_fifo.sv
// Short queue of converted pixels between the front end and the serializer.
// Depends on rup_pkg.
module rup_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr,
   input  rup_pkg::pix_type wdata,
   output logic             full,
   output logic             rd_valid,
   output rup_pkg::pix_type rdata,
   input  logic             rd
);
   import rup_pkg::*;

   pix_type            mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wptr_ff, wptr_in;
   logic [Q_PTR_W-1:0] rptr_ff, rptr_in;
   logic [Q_PTR_W:0]   cnt_ff, cnt_in;
   logic               do_wr, do_rd;

   assign full     = cnt_ff == (Q_PTR_W+1)'(Q_DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rdata    = mem_ff[rptr_ff];
   assign do_wr    = wr && !full;
   assign do_rd    = rd && rd_valid;

   always_comb begin
      wptr_in = do_wr ? wptr_ff + Q_PTR_W'(1) : wptr_ff;
      rptr_in = do_rd ? rptr_ff + Q_PTR_W'(1) : rptr_ff;
      cnt_in  = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + (Q_PTR_W+1)'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - (Q_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

endmodule

FILE: design/rup_back.sv
// Back end: serializes one queued pixel into U,Y,V or Y words and holds the output word.
// Depends on rup_pkg.
module rup_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  rup_pkg::pix_type q_rdata,
   output logic             q_rd,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_run,
   output logic             rsp_end_of_frame
);
   import rup_pkg::*;

   localparam logic [1:0] SLOT_U = 2'd0;
   localparam logic [1:0] SLOT_Y = 2'd1;
   localparam logic [1:0] SLOT_V = 2'd2;

   pix_type    cur_ff;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] slot_ff, slot_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] byte_ff;
   logic       last_ff, eof_ff;

   logic       out_free, emit, is_last, take;
   logic [7:0] byte_sel;

   assign out_free = !out_valid_ff || rsp_pop;
   assign emit     = cur_valid_ff && out_free;
   assign is_last  = cur_ff.even ? (slot_ff == SLOT_V) : 1'b1;
   assign take     = q_valid && (!cur_valid_ff || (emit && is_last));
   assign q_rd     = take;

   always_comb begin
      case (slot_ff)
         SLOT_U:  byte_sel = cur_ff.u;
         SLOT_Y:  byte_sel = cur_ff.y;
         SLOT_V:  byte_sel = cur_ff.v;
         default: byte_sel = cur_ff.y;
      endcase
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      slot_in      = slot_ff;
      if (take) begin
         cur_valid_in = 1'b1;
         slot_in      = q_rdata.even ? SLOT_U : SLOT_Y;
      end else if (emit) begin
         cur_valid_in = !is_last;
         slot_in      = slot_ff + 2'd1;
      end
      out_valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         slot_ff      <= SLOT_U;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         slot_ff      <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cur_ff <= q_rdata;
      end
      if (emit) begin
         byte_ff <= byte_sel;
         last_ff <= is_last;
         eof_ff  <= is_last && cur_ff.eof;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_last_of_run  = last_ff;
   assign rsp_end_of_frame = eof_ff;

endmodule

FILE: design/rgb_to_uyvy_422_packer_core.sv
// RGB to UYVY 4:2:2 packer, top level.
// Instantiates rup_front, rup_fifo and rup_back; depends on rup_pkg.
//
// Usage: push one RGB pixel per word on the req_ side (taken when req_push is
// high and req_full low). The rsp_ side presents packed bytes in U,Y,V,Y order:
// a pixel at an even column gives three words (U, Y, V), one at an odd column
// gives one word (Y). rsp_last_of_run marks the final word of each pixel and
// rsp_end_of_frame the final word of the last pixel of a frame.
// Path: a pixel passes the input stage, the pixel queue, the serializer and
// the output register. The input takes one pixel per cycle while the
// four-entry pixel queue has room; the byte-wide output register sends one
// word per cycle while rsp_pop is high, and a pixel pair gives four words.
// Stall: while rsp_pop is low the output word holds, the serializer and queue
// fill, and req_full rises once the queue and the input stage are both full.
// Reset: counters go to column 0, row 0, line_width to 640, frame_height to
// 480, and all queued words are dropped. Write csr_ registers only when idle.
module rgb_to_uyvy_422_packer_core #(
   parameter int MAX_LINE_WIDTH   = rup_pkg::MAX_LINE_WIDTH_DEF,
   parameter int MAX_FRAME_HEIGHT = rup_pkg::MAX_FRAME_HEIGHT_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [rup_pkg::CFG_W-1:0] csr_wdata,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [7:0]                req_red,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_blue,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last_of_run,
   output logic                      rsp_end_of_frame
);
   import rup_pkg::*;

   logic    q_wr, q_full, q_valid, q_rd;
   pix_type q_wdata, q_rdata;

   rup_front #(
      .MAX_LINE_WIDTH   (MAX_LINE_WIDTH),
      .MAX_FRAME_HEIGHT (MAX_FRAME_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .q_wr      (q_wr),
      .q_wdata   (q_wdata),
      .q_full    (q_full)
   );

   rup_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr       (q_wr),
      .wdata    (q_wdata),
      .full     (q_full),
      .rd_valid (q_valid),
      .rdata    (q_rdata),
      .rd       (q_rd)
   );

   rup_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_rdata          (q_rdata),
      .q_rd             (q_rd),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_frame (rsp_end_of_frame)
   );

   a_eof_on_last : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_end_of_frame) |-> rsp_last_of_run)
      else $error("end of frame on a word that does not close its pixel");

   a_full_needs_queue : assert property (@(posedge clock) disable iff (reset)
      req_full |-> q_full)
      else $error("input stalled while the pixel queue has room");

   a_full_queue_valid : assert property (@(posedge clock) disable iff (reset)
      q_full |-> q_valid)
      else $error("pixel queue full and empty at once");

   a_empty_after_reset : assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("output word present right after reset");

endmodule
